[sv/isvr_pkg.sv]
// shared types, constants and tables of the simpson velocity rotator
package isvr_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORDIC_ITER_DEF  = 16;

  localparam int ATAN_DEPTH = 24;
  localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);
  localparam int ANG_W      = 34;
  localparam int TRIG_W     = 18;
  localparam int MAT_W      = 19;
  localparam int VEL_W      = 32;

  localparam logic [15:0] SCALE_RST = 16'd6799;
  localparam logic [6:0]  WIN_RST   = 7'd8;

  localparam logic signed [ANG_W-1:0] ANGLE_PI      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] ANGLE_HALF_PI = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN   = 34'sd652032874;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_CLOSE  = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  localparam logic [0:0] REG_SCALE = 1'b0;
  localparam logic [0:0] REG_WIN   = 1'b1;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] x;
    logic signed [VEL_W-1:0] y;
    logic signed [VEL_W-1:0] z;
    logic        [31:0]      speed;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MAT,
    ST_ROT,
    ST_SQR,
    ST_ROOT,
    ST_DONE
  } seq_state_e;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      5'd0:    v = 34'sh03243F6A8;
      5'd1:    v = 34'sh01DAC6705;
      5'd2:    v = 34'sh00FADBAFC;
      5'd3:    v = 34'sh007F56EA6;
      5'd4:    v = 34'sh003FEAB76;
      5'd5:    v = 34'sh001FFD55B;
      5'd6:    v = 34'sh000FFFAAA;
      5'd7:    v = 34'sh0007FFF55;
      5'd8:    v = 34'sh0003FFFEA;
      5'd9:    v = 34'sh0001FFFFD;
      5'd10:   v = 34'sh0000FFFFF;
      5'd11:   v = 34'sh00007FFFF;
      5'd12:   v = 34'sh00003FFFF;
      5'd13:   v = 34'sh00001FFFF;
      5'd14:   v = 34'sh00000FFFF;
      5'd15:   v = 34'sh000007FFF;
      5'd16:   v = 34'sh000003FFF;
      5'd17:   v = 34'sh000001FFF;
      5'd18:   v = 34'sh000000FFF;
      5'd19:   v = 34'sh0000007FF;
      5'd20:   v = 34'sh0000003FF;
      5'd21:   v = 34'sh0000001FF;
      5'd22:   v = 34'sh0000000FF;
      5'd23:   v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[sv/isvr_if.sv]
// request and result channel interfaces of the simpson velocity rotator
interface isvr_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  func;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_z;
  logic signed [15:0] heading_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] roll_angle;

  modport source (output valid, func, acc_x, acc_y, acc_z, heading_angle, pitch_angle,
                  roll_angle, input ready);
  modport sink (input valid, func, acc_x, acc_y, acc_z, heading_angle, pitch_angle,
                roll_angle, output ready);
endinterface

interface isvr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rot_vel_x;
  logic signed [31:0] rot_vel_y;
  logic signed [31:0] rot_vel_z;
  logic        [31:0] speed;

  modport source (output valid, rot_vel_x, rot_vel_y, rot_vel_z, speed, input ready);
  modport sink (input valid, rot_vel_x, rot_vel_y, rot_vel_z, speed, output ready);
endinterface

[sv/isvr_cordic.sv]
// one cordic lane: iterative sine and cosine of a q3.13 angle
module isvr_cordic
  import isvr_pkg::*;
#(
  parameter int ITER = CORDIC_ITER_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] angle_i,
  output trig_t              trig_o,
  output logic               busy_o
);

  localparam logic [ATAN_IDX_W-1:0] LAST = ATAN_IDX_W'(ITER - 1);

  logic signed [ANG_W-1:0] x_q, y_q, z_q;
  logic signed [ANG_W-1:0] x_d, y_d, z_d;
  logic signed [ANG_W-1:0] z_in, z0;
  logic signed [ANG_W-1:0] xs, ys, at, xf, yf;
  logic signed [ANG_W:0]   xr, yr;
  logic                    flip_q, flip0;
  logic [ATAN_IDX_W-1:0]   i_q;
  logic                    busy_q;

  always_comb begin
    z_in  = ANG_W'(angle_i) <<< 17;
    z0    = z_in;
    flip0 = 1'b0;
    if (z_in > ANGLE_HALF_PI) begin
      z0    = z_in - ANGLE_PI;
      flip0 = 1'b1;
    end else if (z_in < -ANGLE_HALF_PI) begin
      z0    = z_in + ANGLE_PI;
      flip0 = 1'b1;
    end
  end

  always_comb begin
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    at = atan_q30(i_q);
    if (z_q >= 0) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      i_q    <= '0;
    end else if (busy_q) begin
      i_q <= i_q + 1'b1;
      if (i_q == LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= z0;
      flip_q <= flip0;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  always_comb begin
    xf = flip_q ? -x_q : x_q;
    yf = flip_q ? -y_q : y_q;
    xr = ((ANG_W+1)'(xf) + (ANG_W+1)'(1 << 14)) >>> 15;
    yr = ((ANG_W+1)'(yf) + (ANG_W+1)'(1 << 14)) >>> 15;
    trig_o.c = TRIG_W'(xr);
    trig_o.s = TRIG_W'(yr);
  end

  assign busy_o = busy_q;

endmodule

[sv/isvr_rotate.sv]
// merging sequencer: euler matrix, rotation, squared sum and square root
module isvr_rotate
  import isvr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [2:0]              lane_busy_i,
  input  trig_t                   trig_i [3],
  input  logic signed [VEL_W-1:0] vel_i  [3],
  output logic                    idle_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output result_t                 res_o
);

  localparam logic signed [38:0] R_MAX = 39'sd2147483647;
  localparam logic signed [38:0] R_MIN = -39'sd2147483648;

  seq_state_e state_q, state_d;
  logic [4:0] cnt_q;
  logic       load_res;
  logic       res_valid_q;
  result_t    res_q;

  logic signed [TRIG_W-1:0]  prod_q [14];
  logic signed [TRIG_W-1:0]  ma, mb;
  logic signed [2*TRIG_W-1:0] mp;
  logic signed [2*TRIG_W:0]   mr;
  logic signed [MAT_W-1:0]   m [9];

  logic [3:0]               midx;
  logic signed [MAT_W-1:0]  m_sel;
  logic signed [VEL_W-1:0]  v_sel;
  logic signed [52:0]       acc_q;
  logic signed [38:0]       rr;
  logic signed [VEL_W-1:0]  r_q [3];
  logic signed [VEL_W-1:0]  r_sel;
  logic [31:0]              mag;
  logic [63:0]              sq_q, res_root_q, bit_q, trial;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_TRIG;
      ST_TRIG: if (lane_busy_i == 3'b000) state_d = ST_MAT;
      ST_MAT:  if (cnt_q == 5'd13) state_d = ST_ROT;
      ST_ROT:  if (cnt_q == 5'd11) state_d = ST_SQR;
      ST_SQR:  if (cnt_q == 5'd2) state_d = ST_ROOT;
      ST_ROOT: if (cnt_q == 5'd31) state_d = ST_DONE;
      ST_DONE: if (!res_valid_q || res_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    idle_o   = (state_q == ST_IDLE);
    load_res = (state_q == ST_DONE) && (!res_valid_q || res_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
      if (load_res) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // matrix products, one a cycle
  always_comb begin
    unique case (cnt_q[3:0])
      4'd0:    begin ma = trig_i[2].s; mb = trig_i[1].s; end
      4'd1:    begin ma = trig_i[2].c; mb = trig_i[1].s; end
      4'd2:    begin ma = trig_i[1].c; mb = trig_i[0].c; end
      4'd3:    begin ma = prod_q[0];   mb = trig_i[0].c; end
      4'd4:    begin ma = trig_i[2].c; mb = trig_i[0].s; end
      4'd5:    begin ma = prod_q[1];   mb = trig_i[0].c; end
      4'd6:    begin ma = trig_i[2].s; mb = trig_i[0].s; end
      4'd7:    begin ma = trig_i[1].c; mb = trig_i[0].s; end
      4'd8:    begin ma = prod_q[0];   mb = trig_i[0].s; end
      4'd9:    begin ma = trig_i[2].c; mb = trig_i[0].c; end
      4'd10:   begin ma = prod_q[1];   mb = trig_i[0].s; end
      4'd11:   begin ma = trig_i[2].s; mb = trig_i[0].c; end
      4'd12:   begin ma = trig_i[2].s; mb = trig_i[1].c; end
      4'd13:   begin ma = trig_i[2].c; mb = trig_i[1].c; end
      default: begin ma = '0;          mb = '0;          end
    endcase
    mp = ma * mb;
    mr = ((2*TRIG_W+1)'(mp) + (2*TRIG_W+1)'(1 << 14)) >>> 15;
  end

  always_comb begin
    m[0] = MAT_W'(prod_q[2]);
    m[1] = MAT_W'(prod_q[3]) - MAT_W'(prod_q[4]);
    m[2] = MAT_W'(prod_q[5]) + MAT_W'(prod_q[6]);
    m[3] = MAT_W'(prod_q[7]);
    m[4] = MAT_W'(prod_q[8]) + MAT_W'(prod_q[9]);
    m[5] = MAT_W'(prod_q[10]) - MAT_W'(prod_q[11]);
    m[6] = -MAT_W'(trig_i[1].s);
    m[7] = MAT_W'(prod_q[12]);
    m[8] = MAT_W'(prod_q[13]);
  end

  // rotation: three products and a rounding step per row
  always_comb begin
    midx  = 4'(cnt_q[3:2]) * 4'd3 + 4'(cnt_q[1:0]);
    m_sel = (cnt_q[1:0] == 2'd3) ? '0 : m[midx];
    v_sel = (cnt_q[1:0] == 2'd3) ? '0 : vel_i[cnt_q[1:0]];
    rr    = 39'((acc_q + 53'sd16384) >>> 15);
    r_sel = r_q[cnt_q[1:0]];
    mag   = r_sel[VEL_W-1] ? 32'(-r_sel) : 32'(r_sel);
    trial = res_root_q + bit_q;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        acc_q      <= '0;
        sq_q       <= '0;
        res_root_q <= '0;
        bit_q      <= 64'h4000_0000_0000_0000;
      end
      ST_MAT: begin
        prod_q[cnt_q[3:0]] <= TRIG_W'(mr);
      end
      ST_ROT: begin
        if (cnt_q[1:0] == 2'd3) begin
          if (rr > R_MAX) begin
            r_q[cnt_q[3:2]] <= 32'sh7FFF_FFFF;
          end else if (rr < R_MIN) begin
            r_q[cnt_q[3:2]] <= 32'sh8000_0000;
          end else begin
            r_q[cnt_q[3:2]] <= VEL_W'(rr);
          end
          acc_q <= '0;
        end else begin
          acc_q <= acc_q + 53'(m_sel * v_sel);
        end
      end
      ST_SQR: begin
        sq_q <= sq_q + mag * mag;
      end
      ST_ROOT: begin
        if (sq_q >= trial) begin
          sq_q       <= sq_q - trial;
          res_root_q <= (res_root_q >> 1) + bit_q;
        end else begin
          res_root_q <= res_root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: begin
      end
    endcase
    if (load_res) begin
      res_q.x     <= r_q[0];
      res_q.y     <= r_q[1];
      res_q.z     <= r_q[2];
      res_q.speed <= (res_root_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : res_root_q[31:0];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ST_IDLE)
    else $error("report started while sequencer busy");

  a_trig_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRIG && state_d == ST_MAT) |-> lane_busy_i == 3'b000)
    else $error("matrix step entered with a lane still running");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside the final step");

endmodule

[sv/imu_simpson_velocity_rotator.sv]
// top level: simpson integrator, window registers, cordic lanes and rotation sequencer
// Accelerometer ticks and window closes are accepted back to back while no report is running.
// A report request holds the request side until the sequencer is idle again: the three
// cordic lanes run CORDIC_ITERATIONS steps side by side, then one shared 18x18 multiplier
// builds the euler matrix from 14 products, one 19x32 multiply-accumulate rotates the
// velocities in 12 steps, three squares are summed and a bit-serial square root takes 32
// steps. A finished result sits in an output register, so ticks and closes go on while it waits.
module imu_simpson_velocity_rotator
  import isvr_pkg::*;
#(
  parameter int SAMPLE_WIDTH      = SAMPLE_WIDTH_DEF,
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  isvr_in_if.sink     in_req,
  isvr_out_if.source  out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int SUMW = SW + 8;
  localparam int PW   = SUMW + 17;
  localparam logic signed [63:0] V_MAX = 64'sd2147483647;
  localparam logic signed [63:0] V_MIN = -64'sd2147483648;
  localparam logic signed [SUMW-1:0] S_MAX = {1'b0, {(SUMW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] S_MIN = {1'b1, {(SUMW-1){1'b0}}};

  logic [15:0] scale_q;
  logic [6:0]  win_q, left_q;
  logic        wt_q;
  logic signed [SUMW-1:0]  sum_q [3];
  logic signed [VEL_W-1:0] vel_q [3];
  logic signed [15:0]      ang_q [3];

  logic [15:0]            acc_raw [3];
  logic signed [15:0]     ang_in  [3];
  logic signed [SW-1:0]   smp     [3];
  logic signed [SUMW:0]   tick_add [3], close_add [3];
  logic signed [SUMW-1:0] tick_sum [3], total [3];
  logic signed [PW:0]     vprod   [3];
  logic signed [63:0]     vsh     [3];
  logic signed [VEL_W-1:0] vnew   [3];

  logic        accept, do_tick, do_close, do_report, cfg_wr;
  logic [2:0]  lane_busy;
  trig_t       trig [3];
  logic        idle;
  result_t     res;

  assign acc_raw[0] = in_req.acc_x;
  assign acc_raw[1] = in_req.acc_y;
  assign acc_raw[2] = in_req.acc_z;
  assign ang_in[0]  = in_req.heading_angle;
  assign ang_in[1]  = in_req.pitch_angle;
  assign ang_in[2]  = in_req.roll_angle;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    if (SW <= 16) begin : g_narrow
      assign smp[k] = signed'(acc_raw[k][SW-1:0]);
    end else begin : g_wide
      assign smp[k] = signed'({{(SW-16){1'b0}}, acc_raw[k]});
    end

    always_comb begin
      tick_add[k] = (SUMW+1)'(sum_q[k]) +
                    (wt_q ? ((SUMW+1)'(smp[k]) <<< 1) : ((SUMW+1)'(smp[k]) <<< 2));
      if (tick_add[k][SUMW] != tick_add[k][SUMW-1]) begin
        tick_sum[k] = tick_add[k][SUMW] ? S_MIN : S_MAX;
      end else begin
        tick_sum[k] = SUMW'(tick_add[k]);
      end
      close_add[k] = (SUMW+1)'(sum_q[k]) + (SUMW+1)'(smp[k]);
      if (close_add[k][SUMW] != close_add[k][SUMW-1]) begin
        total[k] = close_add[k][SUMW] ? S_MIN : S_MAX;
      end else begin
        total[k] = SUMW'(close_add[k]);
      end
      vprod[k] = (PW+1)'($signed({1'b0, scale_q}) * total[k]) + (PW+1)'(2048);
      vsh[k]   = 64'(vprod[k] >>> 12);
      if (vsh[k] > V_MAX) begin
        vnew[k] = 32'sh7FFF_FFFF;
      end else if (vsh[k] < V_MIN) begin
        vnew[k] = 32'sh8000_0000;
      end else begin
        vnew[k] = VEL_W'(vsh[k]);
      end
    end

    isvr_cordic #(.ITER(CORDIC_ITERATIONS)) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (do_report),
      .angle_i (ang_q[k]),
      .trig_o  (trig[k]),
      .busy_o  (lane_busy[k])
    );
  end

  assign in_req.ready = idle;
  assign accept    = in_req.valid && in_req.ready;
  assign do_tick   = accept && (in_req.func == FUNC_TICK) && (left_q > 7'd1);
  assign do_close  = accept && (in_req.func == FUNC_CLOSE);
  assign do_report = accept && (in_req.func == FUNC_REPORT);
  assign cfg_wr    = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RST;
      win_q   <= WIN_RST;
      left_q  <= WIN_RST;
      wt_q    <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
        vel_q[k] <= '0;
        ang_q[k] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_SCALE: scale_q <= pwdata[15:0];
          REG_WIN:   win_q   <= pwdata[6:0];
          default:   ;
        endcase
      end
      if (do_tick) begin
        wt_q   <= ~wt_q;
        left_q <= left_q - 7'd1;
        for (int k = 0; k < 3; k++) begin
          sum_q[k] <= tick_sum[k];
        end
      end else if (do_close) begin
        wt_q   <= 1'b0;
        left_q <= win_q;
        for (int k = 0; k < 3; k++) begin
          sum_q[k] <= SUMW'(smp[k]);
          vel_q[k] <= vnew[k];
          ang_q[k] <= ang_in[k];
        end
      end
    end
  end

  assign prdata = (paddr[2] == REG_WIN) ? {25'd0, win_q} : {16'd0, scale_q};
  assign pready = 1'b1;

  isvr_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (do_report),
    .lane_busy_i (lane_busy),
    .trig_i      (trig),
    .vel_i       (vel_q),
    .idle_o      (idle),
    .res_valid_o (out_res.valid),
    .res_ready_i (out_res.ready),
    .res_o       (res)
  );

  assign out_res.rot_vel_x = res.x;
  assign out_res.rot_vel_y = res.y;
  assign out_res.rot_vel_z = res.z;
  assign out_res.speed     = res.speed;

endmodule

[test/imu_simpson_velocity_rotator_tb.sv]
// self-checking testbench of the simpson velocity rotator: directed and random requests against a predictor
module imu_simpson_velocity_rotator_tb;
  import isvr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         func;
    logic signed [15:0] acc[3];
    logic signed [15:0] ang[3];
  } imu_req_t;

  class velocity_scoreboard;
    longint sums[3];
    longint vel[3];
    longint ang[3];
    bit     heavy_next_two;
    int     left;
    int     scale;
    int     win;
    result_t expected_q[$];
    int     errors;
    int     n_tick, n_close, n_report;

    function new();
      for (int i = 0; i < 3; i++) begin
        sums[i] = 0;
        vel[i] = 0;
        ang[i] = 0;
      end
      heavy_next_two = 0;
      left = 8;
      scale = 6799;
      win = 8;
      errors = 0;
    endfunction

    function longint sat(longint v, int w);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function longint rshr(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint mul15(longint a, longint b);
      return rshr(a * b, 15);
    endfunction

    function void sin_cos(longint a, output longint s, output longint c);
      longint z;
      longint x;
      longint y;
      longint nx;
      bit     flip;
      z = a * (64'sd1 <<< 17);
      x = CORDIC_GAIN;
      y = 0;
      flip = 0;
      if (z > ANGLE_HALF_PI) begin
        z -= ANGLE_PI;
        flip = 1;
      end else if (z < -ANGLE_HALF_PI) begin
        z += ANGLE_PI;
        flip = 1;
      end
      for (int i = 0; i < CORDIC_ITER_DEF; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(atan_q30(ATAN_IDX_W'(i)));
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(atan_q30(ATAN_IDX_W'(i)));
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = rshr(x, 15);
      s = rshr(y, 15);
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void set_reg(int idx, int value);
      if (idx == 0) scale = value & 16'hFFFF;
      else if (idx == 1) win = value & 7'h7F;
    endfunction

    function void note_request(imu_req_t r);
      longint w;
      longint total;
      longint sth, cth, sph, cph, sps, cps, ssf, csf, acc_sum;
      longint m[3][3];
      longint rv[3];
      longint unsigned sq;
      longint unsigned root;
      result_t e;
      case (r.func)
        FUNC_TICK: begin
          n_tick++;
          if (left > 1) begin
            w = heavy_next_two ? 2 : 4;
            for (int i = 0; i < 3; i++) sums[i] = sat(sums[i] + w * longint'(r.acc[i]), 24);
            heavy_next_two ^= 1'b1;
            left = (left - 1) & 7'h7F;
          end
        end
        FUNC_CLOSE: begin
          n_close++;
          for (int i = 0; i < 3; i++) begin
            total = sat(sums[i] + longint'(r.acc[i]), 24);
            vel[i] = sat(rshr(longint'(scale) * total, 12), 32);
            sums[i] = r.acc[i];
            ang[i] = r.ang[i];
          end
          heavy_next_two = 0;
          left = win;
        end
        FUNC_REPORT: begin
          n_report++;
          sin_cos(ang[0], sth, cth);
          sin_cos(ang[1], sph, cph);
          sin_cos(ang[2], sps, cps);
          ssf = mul15(sps, sph);
          csf = mul15(cps, sph);
          m[0][0] = mul15(cph, cth);
          m[0][1] = mul15(ssf, cth) - mul15(cps, sth);
          m[0][2] = mul15(csf, cth) + mul15(sps, sth);
          m[1][0] = mul15(cph, sth);
          m[1][1] = mul15(ssf, sth) + mul15(cps, cth);
          m[1][2] = mul15(csf, sth) - mul15(sps, cth);
          m[2][0] = -sph;
          m[2][1] = mul15(sps, cph);
          m[2][2] = mul15(cps, cph);
          sq = 0;
          for (int i = 0; i < 3; i++) begin
            acc_sum = 0;
            for (int j = 0; j < 3; j++) acc_sum += m[i][j] * vel[j];
            rv[i] = sat(rshr(acc_sum, 15), 32);
            sq += longint'(rv[i] < 0 ? -rv[i] : rv[i]) * longint'(rv[i] < 0 ? -rv[i] : rv[i]);
          end
          root = int_sqrt(sq);
          if (root > 64'hFFFF_FFFF) root = 64'hFFFF_FFFF;
          e.x = rv[0][31:0];
          e.y = rv[1][31:0];
          e.z = rv[2][31:0];
          e.speed = root[31:0];
          expected_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t a);
      result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d speed=%0d", $time,
                 a.x, a.y, a.z, a.speed);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.x !== e.x) begin
        $display("%0t: rot_vel_x expected %0d actual %0d", $time, e.x, a.x);
        errors++;
      end
      if (a.y !== e.y) begin
        $display("%0t: rot_vel_y expected %0d actual %0d", $time, e.y, a.y);
        errors++;
      end
      if (a.z !== e.z) begin
        $display("%0t: rot_vel_z expected %0d actual %0d", $time, e.z, a.z);
        errors++;
      end
      if (a.speed !== e.speed) begin
        $display("%0t: speed expected %0d actual %0d", $time, e.speed, a.speed);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  isvr_in_if  in_req ();
  isvr_out_if out_res ();

  imu_simpson_velocity_rotator DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_req  (in_req.sink),
    .out_res (out_res.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  velocity_scoreboard sb = new();
  bit no_stall = 0;
  bit hot_acc = 0;
  int idle_cycles = 0;
  int n_settings = 0;

  initial begin
    in_req.valid = 0;
    in_req.func = FUNC_TICK;
    in_req.acc_x = '0;
    in_req.acc_y = '0;
    in_req.acc_z = '0;
    in_req.heading_angle = '0;
    in_req.pitch_angle = '0;
    in_req.roll_angle = '0;
    out_res.ready = 0;
  end

  always #1 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_stall || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) begin
    if (out_res.valid && out_res.ready) begin
      result_t a;
      a.x = out_res.rot_vel_x;
      a.y = out_res.rot_vel_y;
      a.z = out_res.rot_vel_z;
      a.speed = out_res.speed;
      sb.check_result(a);
    end
    if ((out_res.valid && out_res.ready) || (in_req.valid && in_req.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (no_stall) out_res.ready <= 1'b1;
    else out_res.ready <= ($urandom_range(0, 99) < 65) ? 1'b1 : (gap_len() == 0);
  end

  always @(posedge clk_i) begin
    if (idle_cycles > 6000) begin
      $display("%0t: watchdog expired", $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_request(imu_req_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_req.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_req.valid <= 1'b1;
    in_req.func <= r.func;
    in_req.acc_x <= r.acc[0];
    in_req.acc_y <= r.acc[1];
    in_req.acc_z <= r.acc[2];
    in_req.heading_angle <= r.ang[0];
    in_req.pitch_angle <= r.ang[1];
    in_req.roll_angle <= r.ang[2];
    do @(posedge clk_i); while (!(in_req.valid && in_req.ready));
    sb.note_request(r);
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(int idx, int value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx * 4);
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic signed [15:0] rnd_acc();
    int r;
    r = $urandom_range(0, 99);
    if (hot_acc && r < 70) return 16'sh7FFF;
    if (r < 10) return 16'sh7FFF;
    if (r < 20) return -16'sh8000;
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] rnd_ang();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'sd25736;
    if (r < 20) return -16'sd25736;
    return 16'($urandom_range(0, 51472) - 25736);
  endfunction

  function automatic imu_req_t rnd_req(logic [1:0] f);
    imu_req_t r;
    r.func = f;
    for (int i = 0; i < 3; i++) begin
      r.acc[i] = rnd_acc();
      r.ang[i] = rnd_ang();
    end
    return r;
  endfunction

  task automatic random_phase(int budget);
    int sent;
    int n;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 75) begin
        n = sb.win - 1 + $urandom_range(0, 2);
        if (n > 40 && $urandom_range(0, 3) != 0) n = $urandom_range(1, 8);
        repeat (n) send_request(rnd_req(FUNC_TICK));
        send_request(rnd_req(FUNC_CLOSE));
        send_request(rnd_req(FUNC_REPORT));
        if ($urandom_range(0, 3) == 0) send_request(rnd_req(FUNC_REPORT));
        sent += n + 2;
      end else begin
        send_request(rnd_req(2'($urandom_range(0, 3))));
        sent++;
      end
    end
  endtask

  initial begin
    imu_req_t r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    r = rnd_req(FUNC_REPORT);
    send_request(r);
    for (int k = 0; k < 2; k++) begin
      r.func = FUNC_TICK;
      r.acc[0] = 16'sh7FFF;
      r.acc[1] = -16'sh8000;
      r.acc[2] = k ? 16'sh0000 : 16'shFFFF;
      send_request(r);
    end
    r.func = FUNC_NONE;
    send_request(r);
    r.func = FUNC_CLOSE;
    r.ang[0] = 16'sd25736;
    r.ang[1] = -16'sd25736;
    r.ang[2] = 16'sd12868;
    send_request(r);
    r.func = FUNC_REPORT;
    send_request(r);
    for (int k = 0; k < 9; k++) begin
      r.func = FUNC_TICK;
      r.acc[0] = -16'sh8000;
      r.acc[1] = 16'sh7FFF;
      r.acc[2] = 16'sh5555;
      send_request(r);
    end
    r.func = FUNC_CLOSE;
    r.ang[0] = -16'sd25736;
    r.ang[1] = 16'sd25736;
    r.ang[2] = -16'sd1;
    send_request(r);
    r.func = FUNC_REPORT;
    send_request(r);

    // pause until the output side has caught up
    drain();
    random_phase(90);

    drain();
    write_reg(0, 65535);
    write_reg(1, 127);
    n_settings++;
    hot_acc = 1;
    random_phase(160);
    hot_acc = 0;

    drain();
    write_reg(0, 0);
    write_reg(1, 0);
    n_settings++;
    no_stall = 1;
    random_phase(60);
    no_stall = 0;

    drain();
    write_reg(0, 4096);
    write_reg(1, 1);
    n_settings++;
    random_phase(60);

    drain();
    write_reg(0, 1);
    write_reg(1, 2);
    n_settings++;
    random_phase(80);

    for (int p = 0; p < 4; p++) begin
      drain();
      write_reg(0, $urandom_range(0, 65535));
      write_reg(1, 2 * $urandom_range(1, 32));
      n_settings++;
      no_stall = (p == 1);
      random_phase(95);
    end
    no_stall = 0;

    drain();
    $display("covered %0d ticks, %0d window closes, %0d reports over %0d register settings",
             sb.n_tick, sb.n_close, sb.n_report, n_settings + 1);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/isvr_pkg.sv
sv/isvr_if.sv
sv/isvr_cordic.sv
sv/isvr_rotate.sv
sv/imu_simpson_velocity_rotator.sv
test/imu_simpson_velocity_rotator_tb.sv
